### hw/rtl/mfle_pkg.sv
// ----------------------------------------------------------------------------
// mfle_pkg
// Shared widths, character constants and the run descriptor used by the
// "From " line escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package mfle_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned RunMax  = 6;
  localparam int unsigned RunLenW = 3;

  localparam logic [ByteW-1:0] CharSpace   = 8'h20;
  localparam logic [ByteW-1:0] CharNewline = 8'h0A;
  localparam logic [ByteW-1:0] CharNul     = 8'h00;

  localparam logic [CountW-1:0] CountMax = '1;

  // Item function codes.
  localparam logic FuncData = 1'b0;
  localparam logic FuncEnd  = 1'b1;

  // Bytes written for one accepted item, oldest in entry 0.
  typedef struct packed {
    logic [RunLenW-1:0]             len;
    logic [RunMax-1:0][ByteW-1:0]   bytes;
    logic                           done;
    logic [CountW-1:0]              total;
  } run_t;

  // Characters of the word "From ".
  function automatic logic [ByteW-1:0] from_char(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6D;
      3'd4:    c = CharSpace;
      default: c = CharNul;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mfle_if.sv
// ----------------------------------------------------------------------------
// mfle_if
// Valid/ready channels for message bytes in and mailbox bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfle_in_if
  import mfle_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [ByteW-1:0] data;

  modport source (output valid, func, data, input ready);
  modport sink   (input valid, func, data, output ready);
endinterface

interface mfle_out_if
  import mfle_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  out_byte;
  logic              run_last;
  logic              message_done;
  logic [CountW-1:0] total_bytes;

  modport source (output valid, out_byte, run_last, message_done, total_bytes,
                  input ready);
  modport sink   (input valid, out_byte, run_last, message_done, total_bytes,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/mfle_core.sv
// ----------------------------------------------------------------------------
// mfle_core
// Line state, partial match of "From " and byte count. Turns each accepted
// item into a run of up to six bytes and updates the state in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mfle_core
  import mfle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,
  input  wire logic             accept,
  input  wire logic             func,
  input  wire logic [ByteW-1:0] data,
  output run_t                  run
);

  logic              escape_enable;
  logic              at_line_start;
  logic [2:0]        match_count;
  logic [ByteW-1:0]  last_written;
  logic [CountW-1:0] byte_count;

  logic              at_line_start_next;
  logic [2:0]        match_count_next;
  logic [ByteW-1:0]  last_written_next;
  logic [CountW-1:0] byte_count_next;

  logic              esc_space;
  logic              esc_advance;
  logic              two_newlines;
  logic [ByteW-1:0]  tail_byte;
  logic [RunLenW-1:0] add_len;
  logic [CountW:0]   count_sum;
  logic [CountW-1:0] count_sat;

  assign esc_space   = at_line_start && (match_count == 3'd0) && (data == CharSpace);
  assign esc_advance = at_line_start && (match_count < 3'd5) &&
                       (data == from_char(match_count));
  // Held bytes end in a non-newline, so a flush always forces two newlines.
  assign two_newlines = (match_count != 3'd0) || (last_written != CharNewline);

  assign count_sum = {1'b0, byte_count} + {{(CountW + 1 - RunLenW){1'b0}}, add_len};
  assign count_sat = count_sum[CountW] ? CountMax : count_sum[CountW-1:0];

  // Number of bytes written for the current item.
  always_comb begin
    add_len = '0;
    if (func == FuncData) begin
      if (!escape_enable || !(esc_space || esc_advance)) begin
        add_len = match_count + 3'd1;
      end else if (esc_space) begin
        add_len = 3'd1;
      end else if (match_count == 3'd4) begin
        add_len = 3'd6;
      end
    end else if (escape_enable) begin
      add_len = match_count + 3'd1 + {2'b00, two_newlines};
    end else begin
      add_len = match_count;
    end
  end

  always_comb begin
    run.len   = '0;
    run.done  = 1'b0;
    run.total = '0;
    tail_byte = data;

    at_line_start_next = at_line_start;
    match_count_next   = match_count;
    last_written_next  = last_written;
    byte_count_next    = byte_count;

    if (func == FuncData) begin
      if (!escape_enable || !(esc_space || esc_advance)) begin
        // Flush held bytes, then the byte itself.
        run.len          = add_len;
        match_count_next = '0;
        last_written_next = data;
        byte_count_next  = count_sat;
        if (data == CharNewline) begin
          at_line_start_next = 1'b1;
        end else if (data != CharSpace || match_count != 3'd0) begin
          at_line_start_next = 1'b0;
        end
      end else if (esc_space) begin
        run.len           = add_len;
        last_written_next = CharSpace;
        byte_count_next   = count_sat;
      end else if (match_count < 3'd4) begin
        match_count_next = match_count + 3'd1;
      end else begin
        run.len            = add_len;
        match_count_next   = '0;
        at_line_start_next = 1'b0;
        last_written_next  = CharSpace;
        byte_count_next    = count_sat;
      end
    end else begin
      run.done = 1'b1;
      if (escape_enable) begin
        tail_byte = CharNewline;
        run.len   = add_len;
      end else begin
        tail_byte = CharNul;
        // With nothing held, a single marker byte carries the count.
        run.len   = (match_count == 3'd0) ? 3'd1 : match_count;
      end
      run.total          = count_sat;
      at_line_start_next = 1'b1;
      match_count_next   = '0;
      last_written_next  = CharNul;
      byte_count_next    = '0;
    end

    for (int i = 0; i < RunMax; i++) begin
      run.bytes[i] = (3'(i) < match_count) ? from_char(3'(i)) : tail_byte;
    end
    if (func == FuncData && escape_enable && !esc_space && esc_advance &&
        match_count == 3'd4) begin
      run.bytes[0] = CharSpace;
      for (int i = 1; i < RunMax; i++) begin
        run.bytes[i] = from_char(3'(i - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
      at_line_start <= 1'b1;
      match_count   <= '0;
      last_written  <= CharNul;
      byte_count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        escape_enable <= cfg_wr_data;
      end
      if (accept) begin
        at_line_start <= at_line_start_next;
        match_count   <= match_count_next;
        last_written  <= last_written_next;
        byte_count    <= byte_count_next;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mfle_out_ser.sv
// ----------------------------------------------------------------------------
// mfle_out_ser
// Result register: holds one run and shifts its bytes out one per cycle while dout is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mfle_out_ser
  import mfle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  run_t           run,
  output logic           can_load,
  mfle_out_if.source     dout
);

  logic [RunLenW-1:0]           run_left;
  logic [RunMax-1:0][ByteW-1:0] run_bytes;
  logic                         run_done;
  logic [CountW-1:0]            run_total;
  logic                         taken;
  logic                         is_last;

  assign is_last  = (run_left == RunLenW'(1));
  assign taken    = dout.valid && dout.ready;
  // A new run may enter while the last byte of the current one is taken.
  assign can_load = (run_left == '0) || (is_last && dout.ready);

  assign dout.valid        = (run_left != '0);
  assign dout.out_byte     = run_bytes[0];
  assign dout.run_last     = is_last;
  assign dout.message_done = is_last && run_done;
  assign dout.total_bytes  = (is_last && run_done) ? run_total : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left <= '0;
    end else if (load && run.len != '0) begin
      run_left <= run.len;
    end else if (taken) begin
      run_left <= run_left - RunLenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && run.len != '0) begin
      run_bytes <= run.bytes;
      run_done  <= run.done;
      run_total <= run.total;
    end else if (taken) begin
      run_bytes <= {CharNul, run_bytes[RunMax-1:1]};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mbox_from_line_escaper.sv
// ----------------------------------------------------------------------------
// mbox_from_line_escaper
// Copies a message byte stream to a mailbox. In escape mode it quotes "From " at
// line starts and appends the message terminator newlines.
// ----------------------------------------------------------------------------
//   Channel   Dir  Handshake     Carries
//   din       in   valid/ready   func, data (one message byte or end mark)
//   dout      out  valid/ready   out_byte, run_last, message_done, total_bytes
//   cfg       in   cfg_wr_en     cfg_wr_data -> escape_enable
//
// An item that writes more than one byte holds din off while the result
// register shifts its bytes out; din is ready again as the last byte is taken.
// Bytes held as a partial match write nothing and do not hold din off.
// Synchronous reset clears the line state and sets escape mode.
// A stall on dout backs up into din only once the last byte of the current
// item is waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module mbox_from_line_escaper
  import mfle_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  mfle_in_if.sink     din,
  mfle_out_if.source  dout
);

  run_t run;
  logic can_load;
  logic accept;

  assign din.ready = can_load;
  assign accept    = din.valid && can_load;

  mfle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .func        (din.func),
    .data        (din.data),
    .run         (run)
  );

  mfle_out_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .run      (run),
    .can_load (can_load),
    .dout     (dout)
  );

  // An item is taken only when no earlier byte other than a departing last one waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |-> (!dout.valid || (dout.ready && dout.run_last)))
    else $error("item accepted over a pending run");

  // A run that is not finished keeps presenting bytes.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && !dout.run_last) |=> dout.valid)
    else $error("run ended early");

  // The count is only shown with the end of a message.
  a_total_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.message_done) |-> (dout.total_bytes == '0))
    else $error("total_bytes outside message end");

  // The end of a message closes its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.message_done) |-> dout.run_last)
    else $error("message_done on a non-final byte");

endmodule

`default_nettype wire
